// File: sv/assert_macros.svh
// assertion macros shared by the percent codec modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define FPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fpc assertion failed");

// next-cycle implication
`define FPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fpc assertion failed");

`else

`define FPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define FPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/fpc_pkg.sv
// types, constants and byte classifiers of the percent codec
package fpc_pkg;

  localparam logic [7:0] PCT = 8'h25;

  // job queue between front and back
  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_AW    = 2;

  // one job: the result beats caused by one input beat
  typedef struct packed {
    logic [1:0]      nbeats;
    logic            has_byte;
    logic [2:0][7:0] bytes;
    logic            last;
    logic            was_escaped;
    logic            truncated;
  } job_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] key;
  } match_t;

  // upper-case hex digit of a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'b0, v};
    end else begin
      r = 8'h37 + {4'b0, v};
    end
    return r;
  endfunction

  // the thirty bytes that get escaped
  function automatic logic is_reserved(input logic [7:0] c);
    logic r;
    unique case (c) inside
      [8'h01:8'h08], 8'h0B, 8'h0C, [8'h0E:8'h1F], PCT, 8'h3A: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // first digit of some escape ('0' to '3')
  function automatic logic leads_entry(input logic [7:0] a);
    return (a >= 8'h30) && (a <= 8'h33);
  endfunction

  // two upper-case digits naming a reserved byte
  function automatic match_t match_entry(input logic [7:0] a, input logic [7:0] b);
    match_t     m;
    logic [3:0] lo;
    logic       b_ok;
    b_ok = 1'b0;
    lo   = 4'd0;
    if ((b >= 8'h30) && (b <= 8'h39)) begin
      b_ok = 1'b1;
      lo   = b[3:0];
    end else if ((b >= 8'h41) && (b <= 8'h46)) begin
      b_ok = 1'b1;
      lo   = b[3:0] + 4'd9;
    end
    m.key = {2'b00, a[1:0], lo};
    m.hit = leads_entry(a) && b_ok && is_reserved(m.key);
    return m;
  endfunction

endpackage

// File: sv/fpc_front.sv
// front: accepts name bytes, keeps codec state and builds at most one job per beat
`include "assert_macros.svh"
module fpc_front #(
  parameter int NAME_CHARS = 255
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  logic          in_func,
  input  logic [7:0]    in_ch,
  input  logic          in_last,
  input  logic          q_full,
  output logic          job_wr,
  output fpc_pkg::job_t job
);
  import fpc_pkg::*;

  localparam int LIMIT = 4 * NAME_CHARS;
  localparam int CNT_W = $clog2(LIMIT + 1);

  logic [1:0]       pend_cnt_r, pend_cnt_nxt;
  logic [7:0]       pend_sec_r, pend_sec_nxt;
  logic [CNT_W-1:0] emit_cnt_r, emit_cnt_nxt;
  logic             esc_seen_r, esc_seen_nxt;
  logic             cut_seen_r, cut_seen_nxt;

  logic             acc;
  logic [2:0][7:0]  bv;
  logic [1:0]       n_v;
  logic [1:0]       need;
  logic [CNT_W-1:0] room;
  logic             resv;
  match_t           m;

  assign full = q_full;
  assign acc  = push && !q_full;

  // classify the beat and work out its result bytes
  always_comb begin
    bv           = '0;
    n_v          = 2'd0;
    need         = 2'd0;
    pend_cnt_nxt = pend_cnt_r;
    pend_sec_nxt = pend_sec_r;
    emit_cnt_nxt = emit_cnt_r;
    esc_seen_nxt = esc_seen_r;
    cut_seen_nxt = cut_seen_r;
    resv         = is_reserved(in_ch);
    room         = CNT_W'(LIMIT) - emit_cnt_r;
    m            = match_entry(pend_sec_r, in_ch);
    if (!in_func) begin
      // encode: escape or pass, then apply the length limit
      pend_cnt_nxt = 2'd0;
      pend_sec_nxt = 8'h00;
      if (resv) begin
        need         = 2'd3;
        bv[0]        = PCT;
        bv[1]        = hex_digit(in_ch[7:4]);
        bv[2]        = hex_digit(in_ch[3:0]);
        esc_seen_nxt = 1'b1;
      end else begin
        need  = 2'd1;
        bv[0] = in_ch;
      end
      if (room >= CNT_W'(need)) begin
        n_v = need;
      end else begin
        n_v          = room[1:0];
        cut_seen_nxt = 1'b1;
      end
      emit_cnt_nxt = emit_cnt_r + CNT_W'(n_v);
    end else begin
      // decode: lookahead over up to two held bytes
      case (pend_cnt_r)
        2'd0: begin
          if (in_ch == PCT) begin
            pend_cnt_nxt = 2'd1;
          end else begin
            bv[0] = in_ch;
            n_v   = 2'd1;
          end
        end
        2'd1: begin
          if (leads_entry(in_ch)) begin
            pend_cnt_nxt = 2'd2;
            pend_sec_nxt = in_ch;
          end else if (in_ch == PCT) begin
            bv[0]        = PCT;
            n_v          = 2'd1;
            pend_cnt_nxt = 2'd1;
          end else begin
            bv[0]        = PCT;
            bv[1]        = in_ch;
            n_v          = 2'd2;
            pend_cnt_nxt = 2'd0;
          end
        end
        default: begin
          if (m.hit) begin
            bv[0]        = m.key;
            n_v          = 2'd1;
            pend_cnt_nxt = 2'd0;
          end else if (in_ch == PCT) begin
            bv[0]        = PCT;
            bv[1]        = pend_sec_r;
            n_v          = 2'd2;
            pend_cnt_nxt = 2'd1;
          end else begin
            bv[0]        = PCT;
            bv[1]        = pend_sec_r;
            bv[2]        = in_ch;
            n_v          = 2'd3;
            pend_cnt_nxt = 2'd0;
          end
        end
      endcase
      // flush held bytes at the end of the name
      if (in_last) begin
        if (pend_cnt_nxt == 2'd2) begin
          bv[0] = PCT;
          bv[1] = pend_sec_nxt;
          n_v   = 2'd2;
        end else if (pend_cnt_nxt == 2'd1) begin
          case (n_v)
            2'd0:    bv[0] = PCT;
            2'd1:    bv[1] = PCT;
            default: bv[2] = PCT;
          endcase
          n_v = n_v + 2'd1;
        end
      end
    end
  end

  // job for the queue; an empty final step becomes an end marker
  always_comb begin
    job_wr = acc && ((n_v != 2'd0) || in_last);
    if (n_v == 2'd0) begin
      job.nbeats   = 2'd1;
      job.has_byte = 1'b0;
      job.bytes    = '0;
    end else begin
      job.nbeats   = n_v;
      job.has_byte = 1'b1;
      job.bytes    = bv;
    end
    job.last        = in_last;
    job.was_escaped = in_last && !in_func && esc_seen_nxt;
    job.truncated   = in_last && !in_func && cut_seen_nxt;
  end

  // codec state, cleared at the end of each name
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_cnt_r <= 2'd0;
      pend_sec_r <= 8'h00;
      emit_cnt_r <= '0;
      esc_seen_r <= 1'b0;
      cut_seen_r <= 1'b0;
    end else if (acc) begin
      if (in_last) begin
        pend_cnt_r <= 2'd0;
        pend_sec_r <= 8'h00;
        emit_cnt_r <= '0;
        esc_seen_r <= 1'b0;
        cut_seen_r <= 1'b0;
      end else begin
        pend_cnt_r <= pend_cnt_nxt;
        pend_sec_r <= pend_sec_nxt;
        emit_cnt_r <= emit_cnt_nxt;
        esc_seen_r <= esc_seen_nxt;
        cut_seen_r <= cut_seen_nxt;
      end
    end
  end

  `FPC_ASSERT_NEXT(a_last_clears, clk, rst_n, acc && in_last, (pend_cnt_r == 2'd0) && (emit_cnt_r == '0) && !esc_seen_r && !cut_seen_r)
  `FPC_ASSERT_NOW(a_emit_limit, clk, rst_n, 1'b1, emit_cnt_r <= CNT_W'(LIMIT))
  `FPC_ASSERT_NEXT(a_enc_drops_pend, clk, rst_n, acc && !in_func, pend_cnt_r == 2'd0)

endmodule

// File: sv/fpc_jobq.sv
// short job queue between front and back
`include "assert_macros.svh"
module fpc_jobq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  fpc_pkg::job_t wr_job,
  output logic          q_full,
  input  logic          rd_en,
  output fpc_pkg::job_t head,
  output logic          q_empty
);
  import fpc_pkg::*;

  job_t               mem_r [JOBQ_DEPTH];
  logic [JOBQ_AW-1:0] wr_ptr_r;
  logic [JOBQ_AW-1:0] rd_ptr_r;
  logic [JOBQ_AW:0]   cnt_r;

  assign q_full  = (cnt_r == (JOBQ_AW + 1)'(JOBQ_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign head    = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + JOBQ_AW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + JOBQ_AW'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + (JOBQ_AW + 1)'(1);
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - (JOBQ_AW + 1)'(1);
      end
    end
  end

  `FPC_ASSERT_NOW(a_no_overflow, clk, rst_n, wr_en, !q_full)
  `FPC_ASSERT_NOW(a_no_underflow, clk, rst_n, rd_en, !q_empty)
  `FPC_ASSERT_NEXT(a_cnt_up, clk, rst_n, wr_en && !rd_en, cnt_r == $past(cnt_r) + (JOBQ_AW + 1)'(1))

endmodule

// File: sv/fpc_back.sv
// back: walks the head job one result beat at a time into the output register
`include "assert_macros.svh"
module fpc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  fpc_pkg::job_t q_head,
  output logic          q_rd,
  output logic          empty,
  input  logic          pop,
  output logic          out_has_byte,
  output logic [7:0]    out_byte,
  output logic          out_last,
  output logic          out_was_escaped,
  output logic          out_truncated
);
  import fpc_pkg::*;

  logic [1:0] idx_r;
  logic       ov_r;
  logic       has_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       we_r;
  logic       tr_r;

  logic       load;
  logic       take;
  logic       fin;

  // output register frees when empty or taken
  assign load = !ov_r || pop;
  assign take = load && !q_empty;
  assign fin  = (idx_r == (q_head.nbeats - 2'd1));
  assign q_rd = take && fin;

  assign empty           = !ov_r;
  assign out_has_byte    = has_r;
  assign out_byte        = byte_r;
  assign out_last        = last_r;
  assign out_was_escaped = we_r;
  assign out_truncated   = tr_r;

  // beat index within the head job and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      ov_r  <= 1'b0;
    end else if (load) begin
      ov_r <= take;
      if (take) begin
        idx_r <= fin ? 2'd0 : (idx_r + 2'd1);
      end
    end
  end

  // result beat payload; flags ride on the job's final beat only
  always_ff @(posedge clk) begin
    if (take) begin
      has_r  <= q_head.has_byte;
      byte_r <= q_head.bytes[idx_r];
      last_r <= q_head.last && fin;
      we_r   <= q_head.was_escaped && fin;
      tr_r   <= q_head.truncated && fin;
    end
  end

  `FPC_ASSERT_NOW(a_idx_in_job, clk, rst_n, !q_empty, idx_r < q_head.nbeats)
  `FPC_ASSERT_NOW(a_marker_is_last, clk, rst_n, ov_r && !has_r, last_r)
  `FPC_ASSERT_NOW(a_flags_on_last, clk, rst_n, ov_r && (we_r || tr_r), last_r)

endmodule

// File: sv/filename_percent_codec_unit.sv
// top level of the streaming percent codec for name bytes
// one name byte accepted per cycle while the four-entry job queue has room
// each byte yields up to three result beats, drained one beat per cycle by the back end while pop is given,
// so bytes that expand into several beats lower the sustained input rate
// first result beat passes through the job queue and then the output register before it reaches the ports
// synchronous active-low reset clears codec state, the queue and the output register
module filename_percent_codec_unit #(
  parameter int NAME_CHARS = 255
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic       in_func,
  input  logic [7:0] in_ch,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic       out_has_byte,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_was_escaped,
  output logic       out_truncated
);
  import fpc_pkg::*;

  logic job_wr;
  job_t job;
  logic q_full;
  logic q_rd;
  logic q_empty;
  job_t q_head;

  // classify and build jobs
  fpc_front #(
    .NAME_CHARS(NAME_CHARS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_func (in_func),
    .in_ch   (in_ch),
    .in_last (in_last),
    .q_full  (q_full),
    .job_wr  (job_wr),
    .job     (job)
  );

  // decoupling queue
  fpc_jobq u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_wr),
    .wr_job  (job),
    .q_full  (q_full),
    .rd_en   (q_rd),
    .head    (q_head),
    .q_empty (q_empty)
  );

  // serialize jobs into result beats
  fpc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_rd            (q_rd),
    .empty           (empty),
    .pop             (pop),
    .out_has_byte    (out_has_byte),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .out_was_escaped (out_was_escaped),
    .out_truncated   (out_truncated)
  );

endmodule

// File: tb/tb_filename_percent_codec_unit.sv
// testbench of the percent codec: directed and random name streams checked by a scoreboard
typedef enum bit {
  FUNC_ENCODE = 1'b0,
  FUNC_DECODE = 1'b1
} codec_func_t;

typedef struct packed {
  logic       has_byte;
  logic [7:0] data;
  logic       last;
  logic       was_escaped;
  logic       truncated;
} codec_beat_t;

// predicts the result beats of each accepted byte and checks the popped beats
class codec_scoreboard;
  codec_beat_t expected_q[$];
  codec_beat_t step_beats[$];
  int          keep_limit;
  int          errors;
  logic [1:0]  hold_cnt;
  logic [7:0]  hold_second;
  logic [9:0]  kept_cnt;
  logic        esc_seen;
  logic        cut_seen;

  function new(int name_chars);
    keep_limit = 4 * name_chars;
    errors     = 0;
    clear_state();
  endfunction

  function void clear_state();
    hold_cnt    = 2'd0;
    hold_second = 8'h00;
    kept_cnt    = 10'd0;
    esc_seen    = 1'b0;
    cut_seen    = 1'b0;
  endfunction

  function logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) begin
      return 8'h30 + {4'h0, v};
    end
    return 8'h41 + {4'h0, v - 4'd10};
  endfunction

  function bit needs_escape(logic [7:0] c);
    return (c >= 8'h01 && c <= 8'h08) || c == 8'h0B || c == 8'h0C ||
           (c >= 8'h0E && c <= 8'h1F) || c == fpc_pkg::PCT || c == 8'h3A;
  endfunction

  // upper-case hex digits only
  function bit hex_value(logic [7:0] c, output logic [3:0] v);
    v = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
      return 1'b1;
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      v = c[3:0] + 4'd9;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // digit that begins the escape of some reserved byte
  function bit starts_escape(logic [7:0] a);
    logic [3:0] hi;
    if (!hex_value(a, hi)) begin
      return 1'b0;
    end
    for (int k = 0; k < 16; k++) begin
      if (needs_escape({hi, k[3:0]})) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function bit pair_key(logic [7:0] a, logic [7:0] b, output logic [7:0] key);
    logic [3:0] hi;
    logic [3:0] lo;
    bit         ok;
    ok  = hex_value(a, hi) && hex_value(b, lo);
    key = {hi, lo};
    return ok && needs_escape(key);
  endfunction

  function void put(logic [7:0] b);
    if (step_beats.size() < 3) begin
      step_beats.push_back('{1'b1, b, 1'b0, 1'b0, 1'b0});
    end
  endfunction

  // encoded bytes past the limit are dropped
  function void enc(logic [7:0] b);
    if (kept_cnt < keep_limit) begin
      put(b);
      kept_cnt = kept_cnt + 10'd1;
    end else begin
      cut_seen = 1'b1;
    end
  endfunction

  function void dec_fresh(logic [7:0] c);
    if (c == fpc_pkg::PCT) begin
      hold_cnt = 2'd1;
    end else begin
      put(c);
    end
  endfunction

  function void note_input(codec_func_t f, logic [7:0] c, bit l);
    logic [7:0]  key;
    codec_beat_t tail;
    step_beats.delete();
    if (f == FUNC_ENCODE) begin
      // encode drops whatever the decoder was holding
      hold_cnt    = 2'd0;
      hold_second = 8'h00;
      if (needs_escape(c)) begin
        esc_seen = 1'b1;
        enc(fpc_pkg::PCT);
        enc(hex_char(c[7:4]));
        enc(hex_char(c[3:0]));
      end else begin
        enc(c);
      end
    end else begin
      case (hold_cnt)
        2'd0: begin
          dec_fresh(c);
        end
        2'd1: begin
          if (starts_escape(c)) begin
            hold_cnt    = 2'd2;
            hold_second = c;
          end else begin
            hold_cnt = 2'd0;
            put(fpc_pkg::PCT);
            dec_fresh(c);
          end
        end
        default: begin
          hold_cnt = 2'd0;
          if (pair_key(hold_second, c, key)) begin
            put(key);
          end else begin
            put(fpc_pkg::PCT);
            put(hold_second);
            dec_fresh(c);
          end
        end
      endcase
      // flush held lookahead at the end of the name
      if (l) begin
        if (hold_cnt >= 2'd1) begin
          put(fpc_pkg::PCT);
        end
        if (hold_cnt >= 2'd2) begin
          put(hold_second);
        end
        hold_cnt = 2'd0;
      end
    end
    // final beat carries the name flags, an end marker if nothing was kept
    if (l) begin
      if (step_beats.size() == 0) begin
        step_beats.push_back('0);
      end
      tail             = step_beats[step_beats.size() - 1];
      tail.last        = 1'b1;
      tail.was_escaped = (f == FUNC_ENCODE) && esc_seen;
      tail.truncated   = (f == FUNC_ENCODE) && cut_seen;
      step_beats[step_beats.size() - 1] = tail;
      clear_state();
    end
    foreach (step_beats[i]) begin
      expected_q.push_back(step_beats[i]);
    end
  endfunction

  function void check_result(codec_beat_t got);
    codec_beat_t want;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t unexpected beat: expected none, actual has_byte=%0b byte=%h last=%0b esc=%0b trunc=%0b",
               $time, got.has_byte, got.data, got.last, got.was_escaped, got.truncated);
      return;
    end
    want = expected_q.pop_front();
    if (got.has_byte !== want.has_byte || got.data !== want.data ||
        got.last !== want.last || got.was_escaped !== want.was_escaped ||
        got.truncated !== want.truncated) begin
      errors++;
      $display("%0t mismatch: expected has_byte=%0b byte=%h last=%0b esc=%0b trunc=%0b",
               $time, want.has_byte, want.data, want.last, want.was_escaped, want.truncated);
      $display("%0t           actual   has_byte=%0b byte=%h last=%0b esc=%0b trunc=%0b",
               $time, got.has_byte, got.data, got.last, got.was_escaped, got.truncated);
    end
  endfunction
endclass

module tb_filename_percent_codec_unit;
  import fpc_pkg::*;

  localparam int NAME_CHARS  = 255;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 80;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic       in_func = 1'b0;
  logic [7:0] in_ch = 8'h00;
  logic       in_last = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic       out_has_byte;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_was_escaped;
  logic       out_truncated;

  codec_scoreboard sb;
  int              cycle_cnt = 0;
  int              sent_cnt = 0;
  bit              idle_en = 1'b1;
  bit              hold_req = 1'b0;

  filename_percent_codec_unit #(
    .NAME_CHARS(NAME_CHARS)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_func        (in_func),
    .in_ch          (in_ch),
    .in_last        (in_last),
    .empty          (empty),
    .pop            (pop),
    .out_has_byte   (out_has_byte),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .out_was_escaped(out_was_escaped),
    .out_truncated  (out_truncated)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // offer one input beat, called at a rising edge; stable values are sampled mid-cycle
  task automatic send_item(input codec_func_t f, input logic [7:0] c, input bit l);
    bit taken;
    while (idle_en && $urandom_range(99) < 37) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_func <= f;
    in_ch   <= c;
    in_last <= l;
    do begin
      @(negedge clk);
      taken = !full;
      if (taken) begin
        sb.note_input(f, c, l);
        sent_cnt++;
      end
      @(posedge clk);
    end while (!taken);
  endtask

  function automatic logic [7:0] pick_reserved();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255, 1));
    end while (!sb.needs_escape(c));
    return c;
  endfunction

  // one random name; in decode mode about half of its chunks are well-formed escapes
  task automatic send_random_name();
    logic [7:0]  bytes_q[$];
    logic [7:0]  key;
    codec_func_t f;
    bit          mixed;
    int          chunks;
    int          r;
    f      = codec_func_t'($urandom_range(1, 0));
    mixed  = ($urandom_range(99) < 10);
    chunks = $urandom_range(4, 1);
    for (int k = 0; k < chunks; k++) begin
      r   = $urandom_range(99);
      key = pick_reserved();
      if (f == FUNC_ENCODE) begin
        bytes_q.push_back(r < 50 ? key : 8'($urandom_range(255, 1)));
      end else if (r < 50) begin
        bytes_q.push_back(PCT);
        bytes_q.push_back(sb.hex_char(key[7:4]));
        bytes_q.push_back(sb.hex_char(key[3:0]));
      end else if (r < 62) begin
        bytes_q.push_back(PCT);
        bytes_q.push_back(sb.hex_char(key[7:4]));
      end else if (r < 72) begin
        // lower-case second digit
        bytes_q.push_back(PCT);
        bytes_q.push_back(sb.hex_char(key[7:4]));
        bytes_q.push_back(8'($urandom_range(8'h66, 8'h61)));
      end else if (r < 80) begin
        bytes_q.push_back(PCT);
        bytes_q.push_back(sb.hex_char(4'($urandom_range(15))));
        bytes_q.push_back(8'($urandom_range(255, 1)));
      end else begin
        bytes_q.push_back(8'($urandom_range(255, 1)));
      end
    end
    foreach (bytes_q[i]) begin
      if (mixed) begin
        f = codec_func_t'($urandom_range(1, 0));
      end
      send_item(f, bytes_q[i], i == bytes_q.size() - 1);
    end
  endtask

  // result side: random pops, one long hold-off on request
  initial begin
    int          hold_left;
    codec_beat_t got;
    hold_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= !idle_en || ($urandom_range(99) >= 37);
      end
      @(negedge clk);
      if (pop && !empty) begin
        got = '{out_has_byte, out_byte, out_last, out_was_escaped, out_truncated};
        sb.check_result(got);
      end
    end
  end

  // stimulus
  initial begin
    logic [7:0] enc_dir[$];
    logic [7:0] dec_dir[$];
    int         rand_start;
    int         done_cnt;
    bit         hold_done;
    enc_dir   = '{8'h01, 8'h08, 8'h09, 8'h0B, 8'h0D, 8'h1F, 8'h25, 8'h3A, 8'hFF};
    dec_dir   = '{8'h25, 8'h33, 8'h41, 8'h25, 8'h31, 8'h66, 8'h25, 8'h47,
                  8'h25, 8'h25, 8'h33};
    hold_done = 1'b0;
    sb        = new(NAME_CHARS);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reserved bounds and neighbors, top of the byte range
    foreach (enc_dir[i]) begin
      send_item(FUNC_ENCODE, enc_dir[i], i == enc_dir.size() - 1);
    end
    send_item(FUNC_ENCODE, 8'h41, 1'b1);
    // directed: valid escape, lower-case digit, bad lead, double percent, flush at end
    foreach (dec_dir[i]) begin
      send_item(FUNC_DECODE, dec_dir[i], i == dec_dir.size() - 1);
    end
    // directed: mode changes inside a name
    send_item(FUNC_ENCODE, 8'h61, 1'b0);
    send_item(FUNC_DECODE, PCT, 1'b0);
    send_item(FUNC_ENCODE, 8'h3A, 1'b0);
    send_item(FUNC_DECODE, PCT, 1'b1);

    // random names, a stretch without idling, one receiver hold-off
    rand_start = sent_cnt;
    while (sent_cnt - rand_start < RANDOM_ITEMS) begin
      done_cnt = sent_cnt - rand_start;
      idle_en  = !(done_cnt >= 30 && done_cnt < 70);
      if (done_cnt >= 40 && !hold_done) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
      end
      send_random_name();
    end
    push    <= 1'b0;
    idle_en  = 1'b1;

    // drain
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
